// ===== sv/sbs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared codes and types for the sorted table binary search core.
// ----------------------------------------------------------------------------
package sbs_pkg;

	localparam int unsigned DATA_W = 64;

	// command codes
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// match modes
	localparam logic MODE_EXACT   = 1'b0;
	localparam logic MODE_NEAREST = 1'b1;

	typedef struct packed {
		logic              uns;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic              neg;
		logic              zero;
		logic [DATA_W-1:0] diff;
	} alu_rsp_t;

endpackage

// ===== sv/sbs_chan_if.sv =====
// ----------------------------------------------------------------------------
// sbs_req_if / sbs_rsp_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface sbs_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [63:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sbs_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [7:0]         position;
	logic signed [63:0] matched_value;

	modport source (output valid, output status, output position, output matched_value,
		input ready);
	modport sink   (input valid, input status, input position, input matched_value,
		output ready);
endinterface

// ===== sv/sbs_alu.sv =====
// ----------------------------------------------------------------------------
// sbs_alu
// Shared 65-bit subtractor: a - b with sign or zero extension, giving the
// ordering flags and the distance when the difference is not negative.
// ----------------------------------------------------------------------------
module sbs_alu
	import sbs_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [DATA_W:0] ext_a;
	logic [DATA_W:0] ext_b;
	logic [DATA_W:0] diff;

	always_comb begin
		ext_a = {(req.uns ? 1'b0 : req.a[DATA_W-1]), req.a};
		ext_b = {(req.uns ? 1'b0 : req.b[DATA_W-1]), req.b};
		diff  = ext_a - ext_b;
		rsp.neg  = diff[DATA_W];
		rsp.zero = (diff == '0);
		rsp.diff = diff[DATA_W-1:0];
	end

endmodule

// ===== sv/sbs_ram.sv =====
// ----------------------------------------------------------------------------
// sbs_ram
// Table storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sbs_ram
	import sbs_pkg::*;
#(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/sorted_table_binary_search_core.sv =====
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Sorted table of signed 64-bit values with append, clear and binary search.
// ----------------------------------------------------------------------------
// One command item is handled at a time; req.ready is high only while the
// core is idle, and each item gives exactly one result item through an output
// register. A result still waiting in that register holds the core in its last
// state until the register drains. Clear, dropped or ignored commands and a
// query of an empty table go straight to the result state. An append into a
// table holding N entries walks down from the top one entry per cycle through
// the single table RAM to the new value's sorted place. A query runs up to
// ceil(log2(N)) search steps (RAM read, then compare in the shared
// subtractor), with further distance checks in nearest mode. The table RAM
// needs no clearing after reset: only entries below the fill count are read.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core
	import sbs_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	sbs_req_if.sink       req,
	sbs_rsp_if.source     rsp,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_LO_CMP,
		S_D1_SWAP,
		S_HI_RD,
		S_HI_CMP,
		S_D2_SWAP,
		S_D_CMP,
		S_RESP
	} state_t;

	state_t            state_q;
	logic              mode_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  p_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [CNT_W-1:0]  mid_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] e_lo_q;
	logic [DATA_W-1:0] e_hi_q;
	logic [DATA_W-1:0] d1_q;
	logic [DATA_W-1:0] d2_q;
	logic [1:0]        res_status_q;
	logic [7:0]        res_pos_q;
	logic [DATA_W-1:0] res_val_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [7:0]        out_pos_q;
	logic [DATA_W-1:0] out_val_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	logic [IDX_W-1:0]  p_m1;
	logic [CNT_W:0]    mid_sum;
	logic [CNT_W-1:0]  mid;
	logic [CNT_W-1:0]  span;
	logic [CNT_W-1:0]  lo_p1;
	logic [CNT_W+7:0]  lo_ext;
	logic [CNT_W+7:0]  lo_p1_ext;
	logic [7:0]        lo_pos;
	logic [7:0]        hi_pos;
	logic              entry_le;

	sbs_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sbs_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	always_comb begin
		p_m1      = p_q - IDX_W'(1);
		mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
		mid       = mid_sum[CNT_W:1];
		span      = hi_q - lo_q;
		lo_p1     = lo_q + CNT_W'(1);
		lo_ext    = {8'd0, lo_q};
		lo_p1_ext = {8'd0, lo_p1};
		lo_pos    = lo_ext[7:0];
		hi_pos    = lo_p1_ext[7:0];
		entry_le  = alu_rsp.neg | alu_rsp.zero;
	end

	// RAM and shared subtractor steering
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = p_q;
		ram_wdata   = val_q;
		ram_re      = 1'b0;
		ram_raddr   = p_m1;
		alu_req.uns = 1'b0;
		alu_req.a   = ram_rdata;
		alu_req.b   = val_q;
		unique case (state_q)
			S_INS_RD: begin
				if (p_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_re = 1'b1;
				end
			end
			S_INS_CMP: begin
				ram_we = 1'b1;
				if (!entry_le) begin
					// move the entry up one slot and fetch the next one down
					ram_wdata = ram_rdata;
					ram_re    = (p_q != IDX_W'(1));
					ram_raddr = p_m1 - IDX_W'(1);
				end
			end
			S_SRCH_RD: begin
				ram_re    = 1'b1;
				ram_raddr = (span > CNT_W'(1)) ? mid[IDX_W-1:0] : lo_q[IDX_W-1:0];
			end
			S_LO_CMP: begin
				if (mode_q == MODE_NEAREST) begin
					alu_req.a = val_q;
					alu_req.b = ram_rdata;
				end
			end
			S_D1_SWAP: begin
				alu_req.a = e_lo_q;
				alu_req.b = val_q;
			end
			S_HI_RD: begin
				ram_re    = (lo_p1 < cnt_q);
				ram_raddr = lo_p1[IDX_W-1:0];
			end
			S_D2_SWAP: begin
				alu_req.a = val_q;
				alu_req.b = e_hi_q;
			end
			S_D_CMP: begin
				alu_req.uns = 1'b1;
				alu_req.a   = d1_q;
				alu_req.b   = d2_q;
			end
			default: begin
			end
		endcase
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.position      = out_pos_q;
	assign rsp.matched_value = out_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= MODE_EXACT;
			cnt_q        <= '0;
			p_q          <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			mid_q        <= '0;
			val_q        <= '0;
			e_lo_q       <= '0;
			e_hi_q       <= '0;
			d1_q         <= '0;
			d2_q         <= '0;
			res_status_q <= ST_OK;
			res_pos_q    <= '0;
			res_val_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_pos_q    <= '0;
			out_val_q    <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			// the result state loads or holds the output register itself
			if (rsp.ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						val_q        <= req.value;
						res_status_q <= ST_OK;
						res_pos_q    <= '0;
						res_val_q    <= '0;
						state_q      <= S_RESP;
						unique case (req.cmd)
							CMD_CLEAR: begin
								cnt_q <= '0;
							end
							CMD_APPEND: begin
								if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
									res_status_q <= ST_FULL;
								end else begin
									p_q     <= cnt_q[IDX_W-1:0];
									state_q <= S_INS_RD;
								end
							end
							CMD_QUERY: begin
								if (cnt_q == '0) begin
									res_status_q <= ST_EMPTY;
								end else begin
									lo_q    <= '0;
									hi_q    <= cnt_q;
									state_q <= S_SRCH_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_INS_RD: begin
					if (p_q == '0) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_RESP;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (entry_le) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_RESP;
					end else begin
						p_q <= p_m1;
						if (p_q == IDX_W'(1)) begin
							state_q <= S_INS_RD;
						end
					end
				end
				S_SRCH_RD: begin
					if (span > CNT_W'(1)) begin
						mid_q   <= mid;
						state_q <= S_SRCH_CMP;
					end else begin
						state_q <= S_LO_CMP;
					end
				end
				S_SRCH_CMP: begin
					if (entry_le) begin
						lo_q <= mid_q;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= S_SRCH_RD;
				end
				S_LO_CMP: begin
					e_lo_q <= ram_rdata;
					if (mode_q == MODE_EXACT) begin
						if (alu_rsp.zero) begin
							res_pos_q <= lo_pos;
							res_val_q <= val_q;
						end else begin
							res_status_q <= ST_NOT_FOUND;
						end
						state_q <= S_RESP;
					end else if (alu_rsp.neg) begin
						state_q <= S_D1_SWAP;
					end else begin
						d1_q    <= alu_rsp.diff;
						state_q <= S_HI_RD;
					end
				end
				S_D1_SWAP: begin
					d1_q    <= alu_rsp.diff;
					state_q <= S_HI_RD;
				end
				S_HI_RD: begin
					if (lo_p1 < cnt_q) begin
						state_q <= S_HI_CMP;
					end else begin
						res_pos_q <= lo_pos;
						res_val_q <= e_lo_q;
						state_q   <= S_RESP;
					end
				end
				S_HI_CMP: begin
					e_hi_q <= ram_rdata;
					if (alu_rsp.neg) begin
						state_q <= S_D2_SWAP;
					end else begin
						d2_q    <= alu_rsp.diff;
						state_q <= S_D_CMP;
					end
				end
				S_D2_SWAP: begin
					d2_q    <= alu_rsp.diff;
					state_q <= S_D_CMP;
				end
				S_D_CMP: begin
					// a tie goes to the larger entry
					if (alu_rsp.neg) begin
						res_pos_q <= lo_pos;
						res_val_q <= e_lo_q;
					end else begin
						res_pos_q <= hi_pos;
						res_val_q <= e_hi_q;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					// hold until the output register is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_pos_q    <= res_pos_q;
						out_val_q    <= res_val_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
